>>> rtl/ntha_pkg.sv
package ntha_pkg;

  localparam int unsigned MaxTracksDefault = 16;
  localparam int unsigned CoordW = 25;
  localparam int unsigned RadW = 24;
  localparam int unsigned DriftW = 12;
  localparam int unsigned ResW = 25;
  localparam int unsigned SlotW = 4;
  localparam int unsigned SqW = 52;
  localparam int unsigned RootW = 26;
  localparam logic [ResW-1:0] ResMax = {ResW{1'b1}};
  localparam logic [ResW-1:0] ResThrReset = 25'd512;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_ASSIGN = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_LOADED = 3'd0,
    ST_CLEARED = 3'd1,
    ST_SKIPPED = 3'd2,
    ST_ASSIGNED = 3'd3,
    ST_NOT_ASSIGNED = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SQRT,
    S_RES,
    S_NEXT,
    S_OUT
  } state_t;

  // load word broadcast to every cell of the row
  typedef struct packed {
    logic load;
    logic clear;
    logic [SlotW+3:0] slot;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [RadW-1:0] rad;
  } load_t;

endpackage

>>> rtl/ntha_cell.sv
module ntha_cell #(
  parameter int unsigned Index = 0
) (
  input  logic clk,
  input  logic rst,
  input  ntha_pkg::load_t load_in,
  input  logic shift,
  input  logic signed [ntha_pkg::CoordW-1:0] x_in,
  input  logic signed [ntha_pkg::CoordW-1:0] y_in,
  input  logic [ntha_pkg::RadW-1:0] rad_in,
  input  logic valid_in,
  output logic signed [ntha_pkg::CoordW-1:0] x_out,
  output logic signed [ntha_pkg::CoordW-1:0] y_out,
  output logic [ntha_pkg::RadW-1:0] rad_out,
  output logic valid_out
);

  logic hit;

  assign hit = load_in.load && (load_in.slot == (ntha_pkg::SlotW+4)'(Index));

  // each cell holds one slot; shift rotates the row toward cell 0
  always_ff @(posedge clk) begin
    if (hit) begin
      x_out <= load_in.x;
      y_out <= load_in.y;
      rad_out <= load_in.rad;
    end else if (shift) begin
      x_out <= x_in;
      y_out <= y_in;
      rad_out <= rad_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || load_in.clear) begin
      valid_out <= 1'b0;
    end else if (hit) begin
      valid_out <= 1'b1;
    end else if (shift) begin
      valid_out <= valid_in;
    end
  end

endmodule

>>> rtl/ntha_sqrt.sv
module ntha_sqrt (
  input  logic clk,
  input  logic start,
  input  logic [ntha_pkg::SqW-1:0] n,
  output logic done,
  output logic [ntha_pkg::RootW-1:0] root
);

  localparam int unsigned RemW = ntha_pkg::SqW + 2;

  logic [ntha_pkg::SqW-1:0] rad;
  logic [RemW-1:0] rem;
  logic [ntha_pkg::RootW-1:0] q;
  logic [4:0] cnt;
  logic busy;
  logic [RemW-1:0] trial;
  logic [RemW-1:0] rem_sh;

  // two bits per cycle, restoring, then round to nearest
  always_comb begin
    rem_sh = {rem[RemW-3:0], rad[ntha_pkg::SqW-1 -: 2]};
    trial = rem_sh - {{(RemW-ntha_pkg::RootW-2){1'b0}}, q, 2'b01};
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (start) begin
      rad <= n;
      rem <= '0;
      q <= '0;
      cnt <= 5'(ntha_pkg::RootW);
      busy <= 1'b1;
    end else if (busy) begin
      if (cnt == 5'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
        root <= (rem > {{(RemW-ntha_pkg::RootW){1'b0}}, q}) ? q + 1'b1 : q;
      end else begin
        rad <= {rad[ntha_pkg::SqW-3:0], 2'b00};
        cnt <= cnt - 5'd1;
        if (!trial[RemW-1]) begin
          rem <= trial;
          q <= {q[ntha_pkg::RootW-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          q <= {q[ntha_pkg::RootW-2:0], 1'b0};
        end
      end
    end
  end

endmodule

>>> rtl/nearest_track_hit_assignment.sv
// nearest track hit assignment
// s_axis carries one command word: load a track slot, assign a hit or clear
// all tracks. m_axis returns one status word per command (reserved command
// code three yields none). cfg writes the residual threshold; the user must
// write it only while idle, as the block does not enforce this. tracks live
// in a row of cells that rotates one slot per scan step; cell 0 feeds the
// residual datapath. each valid track takes a square of the offset, a 26-step
// two-bit square root and a residual step, while empty slots are only rotated
// past. s_axis_tready drops while a command is in work or a result waits.
// the result holds in the output register until m_axis_tready; no state is
// lost during a stall. reset empties every slot and sets the threshold to 512.
// one item is worked at a time.
module nearest_track_hit_assignment #(
  parameter int unsigned MaxTracks = ntha_pkg::MaxTracksDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // cmd[1:0] slot[5:2] pos_x[30:6] pos_y[55:31] circle_radius[79:56]
  // drift[91:80] hit_in_use[92] zero[95:93]
  input  logic [95:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // status[2:0] best_slot[6:3] best_residual[31:7]
  output logic [31:0] m_axis_tdata,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [24:0] cfg_data
);

  localparam int unsigned CntW = $clog2(MaxTracks + 1);

  logic [ntha_pkg::ResW-1:0] thr;
  ntha_pkg::state_t state, state_next;
  ntha_pkg::load_t ld;
  logic shift;
  logic signed [ntha_pkg::CoordW-1:0] cx [MaxTracks];
  logic signed [ntha_pkg::CoordW-1:0] cy [MaxTracks];
  logic [ntha_pkg::RadW-1:0] cr [MaxTracks];
  logic cv [MaxTracks];
  logic [CntW-1:0] step;
  logic signed [ntha_pkg::CoordW-1:0] wx, wy;
  logic [ntha_pkg::DriftW-1:0] wd;
  logic [ntha_pkg::CoordW:0] ax, ay;
  logic [ntha_pkg::SqW-1:0] sq;
  logic sq_start, sq_done;
  logic [ntha_pkg::RootW-1:0] root;
  logic [ntha_pkg::RadW-1:0] rad_hold;
  logic [ntha_pkg::RootW:0] d1, d2;
  logic [ntha_pkg::ResW-1:0] res;
  logic found;
  logic [ntha_pkg::SlotW-1:0] best;
  logic [ntha_pkg::ResW-1:0] best_res;
  logic [2:0] o_status;
  logic [ntha_pkg::SlotW-1:0] o_slot;
  logic [ntha_pkg::ResW-1:0] o_res;
  logic accept;
  ntha_pkg::cmd_t cmd;

  assign s_axis_tready = (state == ntha_pkg::S_IDLE) && !m_axis_tvalid;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign cmd = ntha_pkg::cmd_t'(s_axis_tdata[1:0]);
  assign cfg_ready = 1'b1;
  assign m_axis_tdata = {o_res, o_slot, o_status};

  always_comb begin
    ld.load = accept && (cmd == ntha_pkg::CMD_LOAD);
    ld.clear = accept && (cmd == ntha_pkg::CMD_CLEAR);
    ld.slot = {4'b0000, s_axis_tdata[5:2]};
    ld.x = s_axis_tdata[30:6];
    ld.y = s_axis_tdata[55:31];
    ld.rad = s_axis_tdata[79:56];
  end

  for (genvar i = 0; i < MaxTracks; i++) begin : g_cell
    localparam int unsigned Nx = (i + 1) % MaxTracks;
    ntha_cell #(.Index(i)) u_cell (
      .clk, .rst, .load_in(ld), .shift,
      .x_in(cx[Nx]), .y_in(cy[Nx]), .rad_in(cr[Nx]), .valid_in(cv[Nx]),
      .x_out(cx[i]), .y_out(cy[i]), .rad_out(cr[i]), .valid_out(cv[i])
    );
  end

  // square of the offset from the registered ax, ay
  assign sq = ntha_pkg::SqW'(ax * ax) + ntha_pkg::SqW'(ay * ay);

  ntha_sqrt u_sqrt (.clk, .start(sq_start), .n(sq), .done(sq_done), .root);

  always_comb begin
    d1 = ({3'b000, rad_hold} >= {1'b0, root}) ? {3'b000, rad_hold} - {1'b0, root}
                                              : {1'b0, root} - {3'b000, rad_hold};
    d2 = (d1 >= (ntha_pkg::RootW+1)'(wd)) ? d1 - (ntha_pkg::RootW+1)'(wd)
                                          : (ntha_pkg::RootW+1)'(wd) - d1;
    res = (d2 > {2'b00, ntha_pkg::ResMax}) ? ntha_pkg::ResMax : d2[ntha_pkg::ResW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ntha_pkg::S_IDLE;
      thr <= ntha_pkg::ResThrReset;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) thr <= cfg_data;
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      if (accept && cmd != ntha_pkg::CMD_NONE &&
          !(cmd == ntha_pkg::CMD_ASSIGN && !s_axis_tdata[92])) m_axis_tvalid <= 1'b1;
      if (state == ntha_pkg::S_OUT) m_axis_tvalid <= 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    shift = 1'b0;
    sq_start = 1'b0;
    case (state)
      ntha_pkg::S_IDLE: begin
        if (accept && cmd == ntha_pkg::CMD_ASSIGN && !s_axis_tdata[92])
          state_next = ntha_pkg::S_NEXT;
      end
      ntha_pkg::S_NEXT: begin
        if (step == CntW'(MaxTracks)) state_next = ntha_pkg::S_OUT;
        else if (cv[0]) state_next = ntha_pkg::S_MUL;
        else shift = 1'b1;
      end
      ntha_pkg::S_MUL: begin
        sq_start = 1'b1;
        state_next = ntha_pkg::S_SQRT;
      end
      ntha_pkg::S_SQRT: if (sq_done) state_next = ntha_pkg::S_RES;
      ntha_pkg::S_RES: begin
        shift = 1'b1;
        state_next = ntha_pkg::S_NEXT;
      end
      ntha_pkg::S_OUT: state_next = ntha_pkg::S_IDLE;
      default: state_next = ntha_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      wx <= s_axis_tdata[30:6];
      wy <= s_axis_tdata[55:31];
      wd <= s_axis_tdata[91:80];
      step <= '0;
      found <= 1'b0;
      best <= '0;
      best_res <= ntha_pkg::ResMax;
      o_slot <= '0;
      o_res <= '0;
      case (cmd)
        ntha_pkg::CMD_LOAD: o_status <= ntha_pkg::ST_LOADED;
        ntha_pkg::CMD_CLEAR: o_status <= ntha_pkg::ST_CLEARED;
        default: o_status <= ntha_pkg::ST_SKIPPED;
      endcase
    end
    if (state == ntha_pkg::S_NEXT && step != CntW'(MaxTracks)) begin
      ax <= ($signed({cx[0][ntha_pkg::CoordW-1], cx[0]}) >= $signed({wx[ntha_pkg::CoordW-1], wx}))
            ? {cx[0][ntha_pkg::CoordW-1], cx[0]} - {wx[ntha_pkg::CoordW-1], wx}
            : {wx[ntha_pkg::CoordW-1], wx} - {cx[0][ntha_pkg::CoordW-1], cx[0]};
      ay <= ($signed({cy[0][ntha_pkg::CoordW-1], cy[0]}) >= $signed({wy[ntha_pkg::CoordW-1], wy}))
            ? {cy[0][ntha_pkg::CoordW-1], cy[0]} - {wy[ntha_pkg::CoordW-1], wy}
            : {wy[ntha_pkg::CoordW-1], wy} - {cy[0][ntha_pkg::CoordW-1], cy[0]};
      rad_hold <= cr[0];
      if (!cv[0]) step <= step + 1'b1;
    end
    if (state == ntha_pkg::S_RES) begin
      step <= step + 1'b1;
      if (!found || res < best_res) begin
        found <= 1'b1;
        best <= ntha_pkg::SlotW'(step);
        best_res <= res;
      end
    end
    if (state == ntha_pkg::S_OUT) begin
      o_slot <= best;
      o_res <= best_res;
      o_status <= (found && best_res < thr) ? ntha_pkg::ST_ASSIGNED
                                            : ntha_pkg::ST_NOT_ASSIGNED;
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> (state == ntha_pkg::S_IDLE && !m_axis_tvalid))
    else $error("ready while busy");
  a_out_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[2:0] <= 3'd4))
    else $error("bad status");
  a_sqrt_single: assert property (@(posedge clk) disable iff (rst)
    sq_start |=> state == ntha_pkg::S_SQRT)
    else $error("sqrt start lost");
`endif

endmodule

>>> test/tb_nearest_track_hit_assignment.sv
module tb_nearest_track_hit_assignment;

  localparam int unsigned NumTracks = ntha_pkg::MaxTracksDefault;
  localparam int unsigned IdleLimit = 20000;

  typedef struct packed {
    logic [ntha_pkg::ResW-1:0] residual;
    logic [3:0] slot;
    logic [2:0] status;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [24:0] cfg_data = '0;

  nearest_track_hit_assignment i_dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  logic signed [ntha_pkg::CoordW-1:0] trk_x [NumTracks];
  logic signed [ntha_pkg::CoordW-1:0] trk_y [NumTracks];
  logic [ntha_pkg::RadW-1:0] trk_rad [NumTracks];
  logic trk_valid [NumTracks];
  logic [ntha_pkg::ResW-1:0] threshold;

  logic [95:0] pending_words [$];
  verdict_t expected_verdicts [$];
  int errors = 0;
  int idle_cycles = 0;
  bit feeding = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;

  function automatic logic [95:0] pack_word(logic [1:0] cmd, logic [3:0] slot,
      logic [24:0] px, logic [24:0] py, logic [23:0] rad, logic [11:0] drift,
      logic in_use);
    return {3'b000, in_use, drift, rad, py, px, slot, cmd};
  endfunction

  function automatic logic [63:0] round_sqrt(logic [63:0] n);
    logic [63:0] r, b, rem;
    r = 0;
    b = 64'd1 << 62;
    rem = n;
    while (b > rem && b != 0) b = b >> 2;
    while (b != 0) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (rem > r) r = r + 1;
    return r;
  endfunction

  function automatic logic [ntha_pkg::ResW-1:0] track_residual(int t,
      logic signed [24:0] wx, logic signed [24:0] wy, logic [11:0] drift);
    longint dx, dy, d, rad, a, r;
    dx = longint'(trk_x[t]) - longint'(wx);
    dy = longint'(trk_y[t]) - longint'(wy);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    d = longint'(round_sqrt(64'(dx * dx + dy * dy)));
    rad = longint'(trk_rad[t]);
    a = rad >= d ? rad - d : d - rad;
    r = a >= longint'(drift) ? a - longint'(drift) : longint'(drift) - a;
    if (r > longint'(ntha_pkg::ResMax)) r = longint'(ntha_pkg::ResMax);
    return ntha_pkg::ResW'(r);
  endfunction

  // returns 0 when the command yields no result
  function automatic bit predict_verdict(logic [95:0] w, output verdict_t v);
    ntha_pkg::cmd_t cmd;
    logic [3:0] slot;
    logic signed [24:0] px, py;
    logic [11:0] drift;
    logic [ntha_pkg::ResW-1:0] r, best_r;
    int best;
    bit found;
    cmd = ntha_pkg::cmd_t'(w[1:0]);
    slot = w[5:2];
    px = w[30:6];
    py = w[55:31];
    drift = w[91:80];
    v = '0;
    case (cmd)
      ntha_pkg::CMD_LOAD: begin
        if (slot < NumTracks) begin
          trk_x[slot] = px;
          trk_y[slot] = py;
          trk_rad[slot] = w[79:56];
          trk_valid[slot] = 1'b1;
        end
        v.status = ntha_pkg::ST_LOADED;
      end
      ntha_pkg::CMD_CLEAR: begin
        foreach (trk_valid[i]) trk_valid[i] = 1'b0;
        v.status = ntha_pkg::ST_CLEARED;
      end
      ntha_pkg::CMD_NONE: return 0;
      default: begin
        if (w[92]) begin
          v.status = ntha_pkg::ST_SKIPPED;
        end else begin
          found = 0;
          best = 0;
          best_r = ntha_pkg::ResMax;
          for (int t = 0; t < NumTracks; t++) begin
            if (trk_valid[t]) begin
              r = track_residual(t, px, py, drift);
              if (!found || r < best_r) begin
                found = 1;
                best = t;
                best_r = r;
              end
            end
          end
          v.status = (found && best_r < threshold) ? ntha_pkg::ST_ASSIGNED
                                                   : ntha_pkg::ST_NOT_ASSIGNED;
          v.slot = 4'(best);
          v.residual = best_r;
        end
      end
    endcase
    return 1;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) void'(pending_words.pop_front());
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold
      end else if (feeding && pending_words.size() > 0 && gap_left == 0 &&
          !(s_axis_tvalid && s_axis_tready && pending_words.size() == 0)) begin
        if (pending_words.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pending_words[0];
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(0, 6);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end
    end
  end

  // prediction happens at acceptance so table state follows command order
  always @(posedge clk) begin
    verdict_t v;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      if (predict_verdict(s_axis_tdata, v)) expected_verdicts.push_back(v);
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    verdict_t got, want;
    logic rdy;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: rdy = 1'b1;
        1: rdy = ($urandom_range(0, 3) != 0);
        2: rdy = ($urandom_range(0, 3) == 0);
        default: rdy = ($urandom_range(0, 60) == 0) || m_axis_tready;
      endcase
      if (stall_mode == 3 && m_axis_tready && !m_axis_tvalid) rdy = 1'b0;
      m_axis_tready <= rdy;
      if (m_axis_tvalid && m_axis_tready) begin
        got = verdict_t'(m_axis_tdata);
        if (expected_verdicts.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h", $time, got);
          errors++;
        end else begin
          want = expected_verdicts.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
          end
          if (got.slot !== want.slot) begin
            $display("%0t: best_slot expected %0d actual %0d", $time, want.slot, got.slot);
            errors++;
          end
          if (got.residual !== want.residual) begin
            $display("%0t: best_residual expected %0d actual %0d", $time, want.residual,
                     got.residual);
            errors++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready) || rst) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic write_threshold(logic [24:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    threshold = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase();
    feeding = 1'b1;
    wait (pending_words.size() == 0 && !s_axis_tvalid);
    feeding = 1'b0;
    wait (expected_verdicts.size() == 0);
    repeat (600) @(posedge clk);
  endtask

  function automatic logic [24:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return 25'h1000000;
      1: return 25'h0FFFFFF;
      2: return 25'($urandom_range(0, 8000)) - 25'd4000;
      default: return 25'($urandom);
    endcase
  endfunction

  task automatic queue_load(logic [3:0] slot, logic [24:0] x, logic [24:0] y,
      logic [23:0] rad);
    pending_words.push_back(pack_word(ntha_pkg::CMD_LOAD, slot, x, y, rad, 12'($urandom),
                                      1'($urandom)));
  endtask

  task automatic queue_random(int count);
    logic [24:0] cx, cy, wx, wy;
    logic [23:0] rad;
    int sel;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 20) begin
        cx = rand_coord();
        cy = rand_coord();
        rad = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 6000));
        queue_load(4'($urandom), cx, cy, rad);
      end else if (sel < 25) begin
        pending_words.push_back(pack_word(ntha_pkg::CMD_CLEAR, 4'($urandom), 25'($urandom),
            25'($urandom), 24'($urandom), 12'($urandom), 1'($urandom)));
      end else if (sel < 28) begin
        pending_words.push_back(pack_word(ntha_pkg::CMD_NONE, 4'($urandom), 25'($urandom),
            25'($urandom), 24'($urandom), 12'($urandom), 1'($urandom)));
      end else begin
        wx = rand_coord();
        wy = rand_coord();
        pending_words.push_back(pack_word(ntha_pkg::CMD_ASSIGN, 4'($urandom), wx, wy,
            24'($urandom), 12'($urandom), ($urandom_range(0, 7) == 0)));
      end
    end
  endtask

  initial begin
    foreach (trk_valid[i]) begin
      trk_valid[i] = 0;
      trk_x[i] = '0;
      trk_y[i] = '0;
      trk_rad[i] = '0;
    end
    threshold = ntha_pkg::ResThrReset;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, in use, extremes, ties, reserved command
    pending_words.push_back(pack_word(ntha_pkg::CMD_ASSIGN, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(pack_word(ntha_pkg::CMD_ASSIGN, 4'hF, 25'h1FFFFFF, 25'h1FFFFFF,
                                      24'hFFFFFF, 12'hFFF, 1));
    queue_load(0, 0, 0, 24'd1000);
    queue_load(5, 0, 0, 24'd1000);
    pending_words.push_back(pack_word(ntha_pkg::CMD_ASSIGN, 0, 25'd1000, 0, 0, 12'd0, 0));
    pending_words.push_back(pack_word(ntha_pkg::CMD_ASSIGN, 0, 25'd1300, 0, 0, 12'd100, 0));
    pending_words.push_back(pack_word(ntha_pkg::CMD_ASSIGN, 0, 25'd1511, 0, 0, 12'd0, 0));
    pending_words.push_back(pack_word(ntha_pkg::CMD_ASSIGN, 0, 25'd1512, 0, 0, 12'd0, 0));
    queue_load(4'hF, 25'h1000000, 25'h1000000, 24'hFFFFFF);
    queue_load(7, 25'h0FFFFFF, 25'h0FFFFFF, 24'd0);
    pending_words.push_back(pack_word(ntha_pkg::CMD_ASSIGN, 0, 25'h1000000, 25'h0FFFFFF, 0,
                                      12'hFFF, 0));
    pending_words.push_back(pack_word(ntha_pkg::CMD_ASSIGN, 0, 25'h0FFFFFF, 25'h1000000, 0,
                                      12'h555, 0));
    pending_words.push_back(pack_word(ntha_pkg::CMD_NONE, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(pack_word(ntha_pkg::CMD_ASSIGN, 0, 25'd3, 25'd4, 0, 12'd0, 1));
    pending_words.push_back(pack_word(ntha_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(pack_word(ntha_pkg::CMD_ASSIGN, 0, 25'd3, 25'd4, 0, 12'd0, 0));
    queue_load(3, 25'h1FFFFF0, 25'd7, 24'd20);
    pending_words.push_back(pack_word(ntha_pkg::CMD_ASSIGN, 0, 25'h0AAAAAA, 25'h1555555, 0,
                                      12'hAAA, 0));
    run_phase();

    write_threshold(25'd0);
    queue_random(100);
    run_phase();
    write_threshold(25'h1FFFFFF);
    queue_random(100);
    run_phase();
    write_threshold(25'($urandom_range(1, 3000)));
    queue_random(100);
    run_phase();
    write_threshold(25'd512);
    queue_random(100);
    run_phase();

    if (errors == 0 && expected_verdicts.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
